/* hw/rtl/isort_pkg.sv */
// Shared types for the integer array sorter: transaction payloads and control signals.
package isort_pkg;

	localparam int unsigned DATA_W = 32;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     final_res;
		logic                     overflow;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ins;
		logic pop;
	} isort_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic count_one;
	} isort_status_t;

endpackage

/* hw/rtl/isort_ctrl.sv */
// Controller state machine for the integer array sorter: fill and drain phases.
module isort_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	input  logic                    item_last,
	output logic                    item_stall,
	input  isort_pkg::isort_status_t status,
	output isort_pkg::isort_cmd_t    cmd
);
	import isort_pkg::*;

	localparam logic ST_FILL  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic state_q;

	assign item_stall = (state_q == ST_DRAIN);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_FILL: begin
				cmd.ins = item_valid;
			end
			ST_DRAIN: begin
				cmd.pop = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (cmd.ins && item_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (cmd.pop && status.count_one) begin
						state_q <= ST_FILL;
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/isort_dp.sv */
// Datapath of the integer array sorter: sorted insertion row, element counter, overflow flag and output register.
module isort_dp #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  isort_pkg::isort_cmd_t     cmd,
	output isort_pkg::isort_status_t  status,
	input  logic signed [isort_pkg::DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output isort_pkg::out_item_t      out_data
);
	import isort_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

	logic signed [DATA_W-1:0] keys_q [MAX_ITEMS];
	logic [CNT_W-1:0]         count_q;
	logic                     ovf_q;
	logic                     out_valid_q;
	out_item_t                out_q;
	logic [MAX_ITEMS-1:0]     gt;
	logic                     full;

	assign full             = (count_q == CNT_W'(MAX_ITEMS));
	assign status.out_free  = !out_valid_q || !out_stall;
	assign status.count_one = (count_q == CNT_W'(1));
	assign out_valid        = out_valid_q;
	assign out_data         = out_q;

	// Empty slots act as larger than any value, so the new key lands at the
	// first slot that holds a larger key or is empty, and the tail moves up.
	genvar gi;
	generate
		for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
			assign gt[gi] = (CNT_W'(gi) >= count_q) || (keys_q[gi] > value);

			always_ff @(posedge clk) begin
				if (cmd.ins && !full) begin
					if (gt[gi]) begin
						if (gi == 0) begin
							keys_q[gi] <= value;
						end else if (gt[(gi == 0) ? 0 : gi-1]) begin
							keys_q[gi] <= keys_q[(gi == 0) ? 0 : gi-1];
						end else begin
							keys_q[gi] <= value;
						end
					end
				end else if (cmd.pop) begin
					if (gi < MAX_ITEMS-1) begin
						keys_q[gi] <= keys_q[(gi < MAX_ITEMS-1) ? gi+1 : gi];
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.pop) begin
				count_q     <= count_q - CNT_W'(1);
				out_valid_q <= 1'b1;
				if (status.count_one) begin
					ovf_q <= 1'b0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_q.sorted_value <= keys_q[0];
			out_q.final_res    <= status.count_one;
			out_q.overflow     <= ovf_q;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("element count exceeds capacity");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins && cmd.pop))
		else $error("insert and pop issued together");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> out_valid_q)
		else $error("pop did not load the output register");

	a_set_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop && status.count_one |=> (count_q == '0) && !ovf_q)
		else $error("store not emptied after final result of a set");

endmodule

/* hw/rtl/integer_array_sorter_core.sv */
// Top level of the integer array sorter: controller and datapath.
//
// Usage: the input channel (item_valid, item_stall, item) takes one signed
// 32-bit value per transaction, with item.last marking the end of a set.
// While a set is collected, one value is accepted every cycle; each value is
// inserted into a row of MAX_ITEMS compare-and-shift cells that keeps the set
// in ascending order. Values past MAX_ITEMS are dropped and flag overflow.
// After the last value is accepted, item_stall goes high and the row drains
// through the output register, one result per cycle while the result channel
// does not stall; the controller enters the drain state and then pops the
// first result into the output register. result.final_res marks the
// largest value, and result.overflow is set on every result of a set that
// lost values. A stall on the result channel holds the output register and
// pauses the drain. Input is taken again in the cycle after the final result
// is loaded. Reset empties the store and clears the output valid.
module integer_array_sorter_core #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  isort_pkg::in_item_t  item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output isort_pkg::out_item_t result
);
	import isort_pkg::*;

	isort_cmd_t    cmd;
	isort_status_t status;

	isort_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_last  (item.last),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	isort_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.value     (item.value),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_data  (result)
	);

endmodule
